// ===== design/hap_pkg.sv =====
// ----------------------------------------------------------------------------
// hap_pkg
// Shared constants for the heading and axis power pipeline: angle units,
// CORDIC arctangent table, output field widths and register map.
// ----------------------------------------------------------------------------
package hap_pkg;

	// Internal angles are in units of 2^-20 degree.
	localparam int ANG_BITS   = 20;
	localparam int Z_W        = 32;
	localparam int MAX_STAGES = 24;

	localparam logic signed [Z_W-1:0] ONE_DEG = Z_W'(1 << ANG_BITS);
	localparam logic signed [Z_W-1:0] Z_90    = Z_W'(90 << ANG_BITS);
	localparam logic signed [Z_W-1:0] Z_180   = Z_W'(180 << ANG_BITS);
	localparam logic signed [Z_W-1:0] Z_270   = Z_W'(270 << ANG_BITS);
	localparam logic signed [Z_W-1:0] Z_360   = Z_W'(360 << ANG_BITS);

	// atan(2^-i) in units of 2^-20 degree.
	localparam logic signed [Z_W-1:0] ATAN_TAB [MAX_STAGES] = '{
		32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
		32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
		32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
		32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
		32'sd917,      32'sd458,      32'sd229,      32'sd115,
		32'sd57,       32'sd29,       32'sd14,       32'sd7
	};

	// Rotation datapath: Q30 start vector of length 1/K.
	localparam int Q_BITS = 30;
	localparam int R_W    = 32;
	localparam logic signed [R_W-1:0] GAIN_Q30 = 32'sd652032874;

	// Vectoring datapath width and the position scaling target.
	localparam int X_W       = 64;
	localparam int SCALE_TOP = 59;

	// Field widths.
	localparam int HEADING_W = 15;
	localparam int POWER_W   = 8;
	localparam int MAXP_W    = 7;
	localparam logic [MAXP_W-1:0] MAXP_RST = 7'd50;

	// Register map.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_POWER_CAP = '0;

endpackage

// ===== design/hap_vector.sv =====
// ----------------------------------------------------------------------------
// hap_vector
// Pipelined CORDIC in vectoring mode: turns the point pair into a heading in
// 1/2^ANGLE_FRAC_BITS degree, in the range [0, 360).
// ----------------------------------------------------------------------------
module hap_vector #(
	parameter int POS_WIDTH       = 16,
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STAGES   = 16,
	localparam int HW             = $clog2(360 << ANGLE_FRAC_BITS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic signed [POS_WIDTH-1:0] start_x,
	input  logic signed [POS_WIDTH-1:0] start_y,
	input  logic signed [POS_WIDTH-1:0] target_x,
	input  logic signed [POS_WIDTH-1:0] target_y,
	output logic                        h_valid,
	output logic [HW-1:0]               h
);
	import hap_pkg::*;

	localparam int D_W   = POS_WIDTH + 1;
	localparam int SCALE = SCALE_TOP - POS_WIDTH;
	localparam int SH    = ANG_BITS - ANGLE_FRAC_BITS;
	localparam int FULL  = 360 << ANGLE_FRAC_BITS;
	localparam logic [HW-1:0] H_FULL = HW'(FULL);
	localparam logic [HW-1:0] H_90   = HW'(90 << ANGLE_FRAC_BITS);
	localparam logic [HW-1:0] H_180  = HW'(180 << ANGLE_FRAC_BITS);
	localparam logic [HW-1:0] H_270  = HW'(270 << ANGLE_FRAC_BITS);
	localparam logic signed [Z_W-1:0] HALF = Z_W'(1 << (SH - 1));

	// Delta stage.
	logic                  v_s1;
	logic signed [D_W-1:0] dx_s1, dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({target_x[POS_WIDTH-1], target_x})
			       - $signed({start_x[POS_WIDTH-1], start_x});
			dy_s1 <= $signed({target_y[POS_WIDTH-1], target_y})
			       - $signed({start_y[POS_WIDTH-1], start_y});
		end
	end

	// Element 0 is the pre-rotation stage, element k+1 the output of CORDIC step k.
	logic                  v_s  [0:CORDIC_STAGES];
	logic signed [X_W-1:0] x_s  [0:CORDIC_STAGES];
	logic signed [X_W-1:0] y_s  [0:CORDIC_STAGES];
	logic signed [Z_W-1:0] z_s  [0:CORDIC_STAGES];
	logic                  sp_s [0:CORDIC_STAGES];
	logic [HW-1:0]         fh_s [0:CORDIC_STAGES];

	logic signed [X_W-1:0] dxw, dyw;
	assign dxw = X_W'(dx_s1) <<< SCALE;
	assign dyw = X_W'(dy_s1) <<< SCALE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= v_s1;
		end
	end

	// A vector in the left half plane is turned by 180 degrees first.
	// Moves along an axis bypass the CORDIC with an exact heading.
	always_ff @(posedge clk) begin
		if (en) begin
			if (dxw < 0) begin
				x_s[0] <= -dxw;
				y_s[0] <= -dyw;
				z_s[0] <= Z_180;
			end else begin
				x_s[0] <= dxw;
				y_s[0] <= dyw;
				z_s[0] <= '0;
			end
			sp_s[0] <= (dy_s1 == 0) || (dx_s1 == 0);
			if (dy_s1 == 0) begin
				fh_s[0] <= (dx_s1 < 0) ? H_180 : '0;
			end else begin
				fh_s[0] <= (dy_s1 > 0) ? H_90 : H_270;
			end
		end
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		logic signed [X_W-1:0] xs, ys;
		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[k] > 0) begin
					x_s[k+1] <= x_s[k] + ys;
					y_s[k+1] <= y_s[k] - xs;
					z_s[k+1] <= z_s[k] + ATAN_TAB[k];
				end else begin
					x_s[k+1] <= x_s[k] - ys;
					y_s[k+1] <= y_s[k] + xs;
					z_s[k+1] <= z_s[k] - ATAN_TAB[k];
				end
				sp_s[k+1] <= sp_s[k];
				fh_s[k+1] <= fh_s[k];
			end
		end
	end

	// Angle fix stage, then rounding to the output unit.
	logic                  v_sz, sp_sz, v_sh;
	logic signed [Z_W-1:0] z_sz;
	logic [HW-1:0]         fh_sz, h_sh;
	logic signed [Z_W-1:0] zr;
	logic [HW-1:0]         hr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sz <= 1'b0;
			v_sh <= 1'b0;
		end else if (en) begin
			v_sz <= v_s[CORDIC_STAGES];
			v_sh <= v_sz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_sz  <= (z_s[CORDIC_STAGES] < 0) ? z_s[CORDIC_STAGES] + Z_360
			                                  : z_s[CORDIC_STAGES];
			sp_sz <= sp_s[CORDIC_STAGES];
			fh_sz <= fh_s[CORDIC_STAGES];
		end
	end

	assign zr = (z_sz + HALF) >>> SH;
	assign hr = (HW'(zr) >= H_FULL) ? HW'(zr) - H_FULL : HW'(zr);

	always_ff @(posedge clk) begin
		if (en) begin
			h_sh <= sp_sz ? fh_sz : hr;
		end
	end

	assign h_valid = v_sh;
	assign h       = h_sh;

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_sh |-> (h_sh < H_FULL))
		else $error("heading out of range");

endmodule

// ===== design/hap_rotate.sv =====
// ----------------------------------------------------------------------------
// hap_rotate
// Pipelined CORDIC in rotation mode: cosine and sine of the heading, scaled
// by the maximum power and rounded half away from zero.
// ----------------------------------------------------------------------------
module hap_rotate #(
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STAGES   = 16,
	localparam int HW             = $clog2(360 << ANGLE_FRAC_BITS)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   h_valid,
	input  logic [HW-1:0]                          h,
	input  logic [hap_pkg::MAXP_W-1:0]             power_cap,
	output logic                                   o_valid,
	output logic [HW-1:0]                          o_h,
	output logic signed [hap_pkg::POWER_W-1:0]     power_x,
	output logic signed [hap_pkg::POWER_W-1:0]     power_y
);
	import hap_pkg::*;

	localparam int SH  = ANG_BITS - ANGLE_FRAC_BITS;
	localparam int P_W = R_W + MAXP_W + 1;
	localparam logic signed [P_W-1:0] P_HALF = P_W'(1) <<< (Q_BITS - 1);

	logic                  v_s [0:CORDIC_STAGES];
	logic signed [R_W-1:0] x_s [0:CORDIC_STAGES];
	logic signed [R_W-1:0] y_s [0:CORDIC_STAGES];
	logic signed [Z_W-1:0] z_s [0:CORDIC_STAGES];
	logic                  f_s [0:CORDIC_STAGES];
	logic [HW-1:0]         h_s [0:CORDIC_STAGES];

	logic signed [Z_W-1:0] zin;
	assign zin = $signed(Z_W'(h) << SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= h_valid;
		end
	end

	// Fold the heading into [-90, 90]; the left half plane flips both signs.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= GAIN_Q30;
			y_s[0] <= '0;
			h_s[0] <= h;
			if (zin > Z_90 && zin <= Z_270) begin
				z_s[0] <= zin - Z_180;
				f_s[0] <= 1'b1;
			end else if (zin > Z_270) begin
				z_s[0] <= zin - Z_360;
				f_s[0] <= 1'b0;
			end else begin
				z_s[0] <= zin;
				f_s[0] <= 1'b0;
			end
		end
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		logic signed [R_W-1:0] xs, ys;
		assign xs = x_s[k] >>> k;
		assign ys = y_s[k] >>> k;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[k] >= 0) begin
					x_s[k+1] <= x_s[k] - ys;
					y_s[k+1] <= y_s[k] + xs;
					z_s[k+1] <= z_s[k] - ATAN_TAB[k];
				end else begin
					x_s[k+1] <= x_s[k] + ys;
					y_s[k+1] <= y_s[k] - xs;
					z_s[k+1] <= z_s[k] + ATAN_TAB[k];
				end
				f_s[k+1] <= f_s[k];
				h_s[k+1] <= h_s[k];
			end
		end
	end

	// Scale by power_cap, then round from Q30, then apply the sign.
	logic signed [MAXP_W:0]   mp;
	logic                     v_sm, v_sa, v_sn;
	logic signed [P_W-1:0]    px_sm, py_sm;
	logic                     f_sm;
	logic [HW-1:0]            h_sm, h_sa, h_sn;
	logic [POWER_W-1:0]       mx_sa, my_sa;
	logic                     nx_sa, ny_sa;
	logic signed [POWER_W-1:0] px_sn, py_sn;
	logic signed [P_W-1:0]    ax, ay;

	assign mp = $signed({1'b0, power_cap});
	assign ax = (px_sm < 0) ? -px_sm : px_sm;
	assign ay = (py_sm < 0) ? -py_sm : py_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm <= 1'b0;
			v_sa <= 1'b0;
			v_sn <= 1'b0;
		end else if (en) begin
			v_sm <= v_s[CORDIC_STAGES];
			v_sa <= v_sm;
			v_sn <= v_sa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_sm <= P_W'(x_s[CORDIC_STAGES]) * P_W'(mp);
			py_sm <= P_W'(y_s[CORDIC_STAGES]) * P_W'(mp);
			f_sm  <= f_s[CORDIC_STAGES];
			h_sm  <= h_s[CORDIC_STAGES];

			mx_sa <= POWER_W'((ax + P_HALF) >>> Q_BITS);
			my_sa <= POWER_W'((ay + P_HALF) >>> Q_BITS);
			nx_sa <= (px_sm < 0) ^ f_sm;
			ny_sa <= (py_sm < 0) ^ f_sm;
			h_sa  <= h_sm;

			px_sn <= nx_sa ? -$signed(mx_sa) : $signed(mx_sa);
			py_sn <= ny_sa ? -$signed(my_sa) : $signed(my_sa);
			h_sn  <= h_sa;
		end
	end

	assign o_valid = v_sn;
	assign o_h     = h_sn;
	assign power_x = px_sn;
	assign power_y = py_sn;

endmodule

// ===== design/hap_outbuf.sv =====
// ----------------------------------------------------------------------------
// hap_outbuf
// Output register with one skid entry. Stalls the pipeline only when both
// entries hold a result.
// ----------------------------------------------------------------------------
module hap_outbuf (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push_valid,
	input  logic [hap_pkg::HEADING_W-1:0]          push_heading,
	input  logic signed [hap_pkg::POWER_W-1:0]     push_power_x,
	input  logic signed [hap_pkg::POWER_W-1:0]     push_power_y,
	output logic                                   en,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [hap_pkg::HEADING_W-1:0]          heading,
	output logic signed [hap_pkg::POWER_W-1:0]     power_x,
	output logic signed [hap_pkg::POWER_W-1:0]     power_y
);
	import hap_pkg::*;

	logic                      out_valid_q, skid_valid_q;
	logic [HEADING_W-1:0]      heading_q, skid_heading_q;
	logic signed [POWER_W-1:0] power_x_q, power_y_q, skid_power_x_q, skid_power_y_q;
	logic                      load;
	logic                      push;

	assign en   = !skid_valid_q;
	assign push = push_valid && en;
	assign load = out_ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (skid_valid_q) begin
				heading_q <= skid_heading_q;
				power_x_q <= skid_power_x_q;
				power_y_q <= skid_power_y_q;
			end else begin
				heading_q <= push_heading;
				power_x_q <= push_power_x;
				power_y_q <= push_power_y;
			end
		end else if (push) begin
			skid_heading_q <= push_heading;
			skid_power_x_q <= push_power_x;
			skid_power_y_q <= push_power_y;
		end
	end

	assign out_valid = out_valid_q;
	assign heading   = heading_q;
	assign power_x   = power_x_q;
	assign power_y   = power_y_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !out_ready && push_valid))
		else $error("skid entry filled without a stalled output");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_ready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid entry not moved to the output register");

endmodule

// ===== design/heading_to_axis_power_core.sv =====
// Throughput: one transaction per cycle while the skid entry is empty.
// Every CORDIC step has its own register stage.
// A one-entry skid buffer behind the output register keeps the input open while a result waits.
// Reset (arst_n low, asynchronous) clears all valid bits and sets power_cap to 50.
// ----------------------------------------------------------------------------
// heading_to_axis_power_core
// Heading from a start point to a target point, and the x and y drive powers
// power_cap * cos(heading) and power_cap * sin(heading).
// ----------------------------------------------------------------------------
module heading_to_axis_power_core #(
	parameter int POS_WIDTH       = 16,
	parameter int ANGLE_FRAC_BITS = 6,
	parameter int CORDIC_STAGES   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [hap_pkg::APB_ADDR_W-1:0]         paddr,
	input  logic [hap_pkg::APB_DATA_W-1:0]         pwdata,
	output logic [hap_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                   pready,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [POS_WIDTH-1:0]            start_x,
	input  logic signed [POS_WIDTH-1:0]            start_y,
	input  logic signed [POS_WIDTH-1:0]            target_x,
	input  logic signed [POS_WIDTH-1:0]            target_y,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [hap_pkg::HEADING_W-1:0]          heading,
	output logic signed [hap_pkg::POWER_W-1:0]     power_x,
	output logic signed [hap_pkg::POWER_W-1:0]     power_y
);
	import hap_pkg::*;

	localparam int HW = $clog2(360 << ANGLE_FRAC_BITS);

	logic [MAXP_W-1:0]          power_cap_q;
	logic [REG_IDX_W-1:0]       reg_idx;
	logic                       en;
	logic                       h_valid, r_valid;
	logic [HW-1:0]              h, r_h;
	logic signed [POWER_W-1:0]  r_power_x, r_power_y;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_cap_q <= MAXP_RST;
		end else if (psel && penable && pwrite && reg_idx == REG_POWER_CAP) begin
			power_cap_q <= pwdata[MAXP_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_POWER_CAP: prdata = APB_DATA_W'(power_cap_q);
			default:       prdata = '0;
		endcase
	end

	assign in_ready = en;

	hap_vector #(
		.POS_WIDTH       (POS_WIDTH),
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STAGES   (CORDIC_STAGES)
	) u_vector (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.start_x  (start_x),
		.start_y  (start_y),
		.target_x (target_x),
		.target_y (target_y),
		.h_valid  (h_valid),
		.h        (h)
	);

	hap_rotate #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
		.CORDIC_STAGES   (CORDIC_STAGES)
	) u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.h_valid   (h_valid),
		.h         (h),
		.power_cap (power_cap_q),
		.o_valid   (r_valid),
		.o_h       (r_h),
		.power_x   (r_power_x),
		.power_y   (r_power_y)
	);

	hap_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_valid   (r_valid),
		.push_heading (HEADING_W'(r_h)),
		.push_power_x (r_power_x),
		.push_power_y (r_power_y),
		.en           (en),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.heading      (heading),
		.power_x      (power_x),
		.power_y      (power_y)
	);

endmodule

// ===== tb/sv/tb_heading_to_axis_power_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heading_to_axis_power_core
// Self-checking bench for the heading and axis power pipeline. Point pairs go
// in over a valid/ready channel in random bursts, and results leave through a
// receiver that stalls in changing patterns. A cycle-free model of the two
// CORDIC passes predicts heading, power_x and power_y for every accepted
// transaction. The power cap is rewritten over APB between phases and read back.
// ----------------------------------------------------------------------------
module tb_heading_to_axis_power_core;

	localparam int POS_W        = 16;
	localparam int FRAC_BITS    = 6;
	localparam int STAGES       = 16;
	localparam int LATENCY      = 2 * STAGES + 9;
	localparam int DRAIN_CYCLES = LATENCY + 16;
	localparam int IDLE_LIMIT   = 4000;
	localparam int PER_PHASE    = 285;

	// Degrees in a half and a full turn.
	localparam longint HALF_TURN = 180;
	localparam longint FULL_TURN = 360;
	localparam int     TO_OUT    = hap_pkg::ANG_BITS - FRAC_BITS;
	localparam int     SCALE_SH  = hap_pkg::SCALE_TOP - POS_W;

	localparam logic [hap_pkg::APB_ADDR_W-1:0] MAXP_ADDR = {hap_pkg::REG_POWER_CAP, 2'b00};

	typedef struct {
		logic signed [POS_W-1:0] sx;
		logic signed [POS_W-1:0] sy;
		logic signed [POS_W-1:0] tx;
		logic signed [POS_W-1:0] ty;
	} move_t;

	typedef struct {
		logic [hap_pkg::HEADING_W-1:0]      heading;
		logic signed [hap_pkg::POWER_W-1:0] power_x;
		logic signed [hap_pkg::POWER_W-1:0] power_y;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [hap_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [hap_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [hap_pkg::APB_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [POS_W-1:0] start_x = '0;
	logic signed [POS_W-1:0] start_y = '0;
	logic signed [POS_W-1:0] target_x = '0;
	logic signed [POS_W-1:0] target_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [hap_pkg::HEADING_W-1:0] heading;
	logic signed [hap_pkg::POWER_W-1:0] power_x;
	logic signed [hap_pkg::POWER_W-1:0] power_y;

	move_t  pending_moves[$];
	drive_t awaited_drives[$];
	move_t  next_move;
	drive_t want;
	logic [hap_pkg::MAXP_W-1:0] power_limit = hap_pkg::MAXP_RST;

	int fail_count = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int stall_timer = 0;
	int stall_phase = 0;
	int idle_cycles = 0;
	logic [7:0] stall_pattern = 8'b1011_0010;

	heading_to_axis_power_core #(
		.POS_WIDTH(POS_W),
		.ANGLE_FRAC_BITS(FRAC_BITS),
		.CORDIC_STAGES(STAGES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.start_x(start_x),
		.start_y(start_y),
		.target_x(target_x),
		.target_y(target_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.heading(heading),
		.power_x(power_x),
		.power_y(power_y)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Rounds a Q30 product to an integer, halves away from zero.
	function automatic longint round_q30(input longint p);
		longint half;
		half = longint'(1) <<< 29;
		if (p >= 0)
			return (p + half) >>> 30;
		return -(((-p) + half) >>> 30);
	endfunction

	// Heading by vectoring CORDIC, then cos/sin powers by rotation CORDIC.
	function automatic drive_t heading_and_drive(input move_t m, input longint mp);
		drive_t r;
		longint dx, dy, x, y, z, xs, ys, h, px, py, one_deg, full;
		bit flip;
		one_deg = longint'(1) <<< hap_pkg::ANG_BITS;
		full = FULL_TURN <<< FRAC_BITS;
		dx = longint'(m.tx) - longint'(m.sx);
		dy = longint'(m.ty) - longint'(m.sy);
		if (dy == 0) begin
			h = (dx < 0) ? (HALF_TURN <<< FRAC_BITS) : 0;
		end else if (dx == 0) begin
			h = (dy > 0) ? ((HALF_TURN / 2) <<< FRAC_BITS) : ((3 * HALF_TURN / 2) <<< FRAC_BITS);
		end else begin
			x = dx <<< SCALE_SH;
			y = dy <<< SCALE_SH;
			z = 0;
			if (x < 0) begin
				x = -x;
				y = -y;
				z = HALF_TURN * one_deg;
			end
			for (int i = 0; i < STAGES; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y > 0) begin
					x = x + ys;
					y = y - xs;
					z = z + longint'(hap_pkg::ATAN_TAB[i]);
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - longint'(hap_pkg::ATAN_TAB[i]);
				end
			end
			if (z < 0)
				z = z + FULL_TURN * one_deg;
			h = (z + (longint'(1) <<< (TO_OUT - 1))) >>> TO_OUT;
			if (h >= full)
				h = h - full;
		end

		// Fold the heading into the right half plane before rotating.
		z = h <<< TO_OUT;
		flip = 1'b0;
		if (z > (HALF_TURN / 2) * one_deg && z <= (3 * HALF_TURN / 2) * one_deg) begin
			z = z - HALF_TURN * one_deg;
			flip = 1'b1;
		end else if (z > (3 * HALF_TURN / 2) * one_deg) begin
			z = z - FULL_TURN * one_deg;
		end
		x = longint'(hap_pkg::GAIN_Q30);
		y = 0;
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - longint'(hap_pkg::ATAN_TAB[i]);
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + longint'(hap_pkg::ATAN_TAB[i]);
			end
		end
		px = round_q30(mp * x);
		py = round_q30(mp * y);
		if (flip) begin
			px = -px;
			py = -py;
		end
		r.heading = h[hap_pkg::HEADING_W-1:0];
		r.power_x = px[hap_pkg::POWER_W-1:0];
		r.power_y = py[hap_pkg::POWER_W-1:0];
		return r;
	endfunction

	function automatic void report_mismatch(input string what, input longint exp_val,
			input longint got_val);
		fail_count++;
		$display("%0t: %s expected %0d, got %0d", $time, what, exp_val, got_val);
	endfunction

	function automatic void add_move(input int sx, input int sy, input int tx, input int ty);
		move_t m;
		m.sx = sx[POS_W-1:0];
		m.sy = sy[POS_W-1:0];
		m.tx = tx[POS_W-1:0];
		m.ty = ty[POS_W-1:0];
		pending_moves.push_back(m);
	endfunction

	// Mostly structured moves (short hops, axis-aligned, diagonal, zero length)
	// on top of fully random point pairs.
	function automatic void add_random_move();
		move_t m;
		int unsigned pick;
		logic signed [POS_W-1:0] d;
		m.sx = POS_W'($urandom());
		m.sy = POS_W'($urandom());
		m.tx = POS_W'($urandom());
		m.ty = POS_W'($urandom());
		d = POS_W'($urandom());
		pick = $urandom_range(0, 99);
		if (pick >= 35 && pick < 65) begin
			m.tx = m.sx + POS_W'($urandom_range(0, 64) - 32);
			m.ty = m.sy + POS_W'($urandom_range(0, 64) - 32);
		end else if (pick >= 65 && pick < 80) begin
			if ($urandom_range(0, 1) == 0)
				m.ty = m.sy;
			else
				m.tx = m.sx;
		end else if (pick >= 80 && pick < 92) begin
			m.tx = m.sx + d;
			m.ty = ($urandom_range(0, 1) == 0) ? m.sy + d : m.sy - d;
		end else if (pick >= 92) begin
			m.tx = m.sx;
			m.ty = m.sy;
		end
		pending_moves.push_back(m);
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				next_move.sx = start_x;
				next_move.sy = start_y;
				next_move.tx = target_x;
				next_move.ty = target_y;
				awaited_drives.push_back(heading_and_drive(next_move, longint'(power_limit)));
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0 || pending_moves.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					next_move = pending_moves.pop_front();
					start_x <= next_move.sx;
					start_y <= next_move.sy;
					target_x <= next_move.tx;
					target_y <= next_move.ty;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Receiver: checks each result transaction and stalls in a changing mode.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (awaited_drives.size() == 0) begin
					report_mismatch("unexpected result, heading", -1, longint'(heading));
				end else begin
					want = awaited_drives.pop_front();
					if (heading !== want.heading)
						report_mismatch("heading", longint'(want.heading), longint'(heading));
					if (power_x !== want.power_x)
						report_mismatch("power_x", longint'(want.power_x), longint'(power_x));
					if (power_y !== want.power_y)
						report_mismatch("power_y", longint'(want.power_y), longint'(power_y));
				end
			end
			if (stall_timer == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_timer = $urandom_range(50, 300);
				stall_pattern = 8'($urandom());
			end else begin
				stall_timer--;
			end
			stall_phase = (stall_phase + 1) % 8;
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 7) == 0);
				default: out_ready <= stall_pattern[stall_phase];
			endcase
		end
	end

	// Watchdog: any transaction on either channel or the APB port counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("heading_to_axis_power_core: mismatch");
				$finish;
			end
		end
	end

	// Write the power cap, then read it back in the next APB transfer.
	task automatic write_power_limit(input logic [hap_pkg::APB_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MAXP_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		power_limit = value[hap_pkg::MAXP_W-1:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== hap_pkg::APB_DATA_W'(power_limit))
			report_mismatch("power_cap read", longint'(power_limit), longint'(prdata));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic wait_until_drained();
		while (pending_moves.size() != 0 || in_valid || awaited_drives.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [hap_pkg::APB_DATA_W-1:0] settings[$];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed moves at the reset value of the power cap.
		add_move(0, 0, 0, 0);
		add_move(-32768, -32768, -32768, -32768);
		add_move(32767, 32767, 32767, 32767);
		add_move(0, 0, 100, 0);
		add_move(0, 0, -100, 0);
		add_move(0, 0, 0, 100);
		add_move(0, 0, 0, -100);
		add_move(-32768, 0, 32767, 0);
		add_move(32767, 0, -32768, 0);
		add_move(0, -32768, 0, 32767);
		add_move(0, 32767, 0, -32768);
		add_move(-32768, -32768, 32767, 32767);
		add_move(32767, -32768, -32768, 32767);
		add_move(32767, 32767, -32768, -32768);
		add_move(-32768, 32767, 32767, -32768);
		add_move(0, 0, 1, 1);
		add_move(0, 0, -1, 1);
		add_move(0, 0, 1, -1);
		add_move(0, 0, 32767, 1);
		add_move(0, 0, 32767, -1);
		add_move(0, 0, -32768, 1);
		add_move(0, 0, -32768, -1);
		add_move(0, 0, 1, 32767);
		add_move(0, 0, -1, -32768);
		add_move(5, -7, -3, 12);
		wait_until_drained();

		// Fixed values and extremes first, then a random value and a random value with junk above the register field.
		settings = '{32'd100, 32'd0, 32'd127, 32'd1, 32'd0, 32'd0};
		settings[4] = $urandom_range(2, 99);
		settings[5] = {$urandom()} & 32'hFFFF_FF80 | $urandom_range(0, 127);
		foreach (settings[k]) begin
			write_power_limit(settings[k]);
			for (int n = 0; n < PER_PHASE; n++)
				add_random_move();
			wait_until_drained();
		end

		if (fail_count == 0)
			$display("heading_to_axis_power_core: match");
		else
			$display("heading_to_axis_power_core: mismatch");
		$finish;
	end

endmodule

// ===== heading_to_axis_power_core.f =====
design/hap_pkg.sv
design/hap_vector.sv
design/hap_rotate.sv
design/hap_outbuf.sv
design/heading_to_axis_power_core.sv
tb/sv/tb_heading_to_axis_power_core.sv
